// ----- hdl/rcube_pkg.sv -----
// Shared types and constants for the rational cubic evaluator.
// Depends on nothing; imported by the front end, the back end and the top level.
`default_nettype none
package rcube_pkg;

    localparam int COEF_WIDTH  = 32;
    localparam int COORD_WIDTH = 32;
    localparam int NUM_TERMS   = 20;
    localparam int IDX_WIDTH   = 5;
    localparam int RATIO_WIDTH = 48;

    localparam logic [1:0] ACT_LOAD_NUM = 2'd0;
    localparam logic [1:0] ACT_LOAD_DEN = 2'd1;
    localparam logic [1:0] ACT_EVAL     = 2'd2;

    typedef enum logic [1:0] {
        ENT_LOAD_NUM = 2'b01,
        ENT_LOAD_DEN = 2'b10,
        ENT_EVAL     = 2'b11
    } entry_kind_t;

    typedef struct packed {
        logic [1:0]                    action;
        logic [IDX_WIDTH-1:0]          coef_index;
        logic signed [COEF_WIDTH-1:0]  coef_value;
        logic signed [COORD_WIDTH-1:0] coord_x;
        logic signed [COORD_WIDTH-1:0] coord_y;
        logic signed [COORD_WIDTH-1:0] coord_z;
    } request_t;

    typedef struct packed {
        logic signed [RATIO_WIDTH-1:0] ratio_value;
        logic                          denominator_zero;
        logic                          saturated;
    } result_t;

    // Queue entry: coefficient in Q.24, coordinates in Q.30, 32 bits each
    typedef struct packed {
        entry_kind_t          kind;
        logic [IDX_WIDTH-1:0] idx;
        logic signed [31:0]   coef;
        logic signed [31:0]   x;
        logic signed [31:0]   y;
        logic signed [31:0]   z;
    } entry_t;

endpackage
`default_nettype wire

// ----- hdl/rcube_fifo.sv -----
// Small first-in first-out queue of flat words.
// Depends on nothing; used for the work queue and the result queue.
`default_nettype none
module rcube_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [CW-1:0]    count_reg;
    logic             wr, rd;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign wr    = push && !full;
    assign rd    = pop && !empty;
    assign rdata = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (rd)
            begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- hdl/rcube_front.sv -----
// Front end: classifies requests and brings fields to internal fixed point.
// Depends on rcube_pkg.
`default_nettype none
module rcube_front
    import rcube_pkg::*;
(
    input  wire request_t req,
    output entry_t        entry,
    output logic          keep
);
    logic signed [31:0] coef_n, x_n, y_n, z_n;

    // Floor shift for wide fields, plain left shift for narrow ones
    generate
        if (COEF_WIDTH > 32)
        begin : g_coef_wide
            assign coef_n = 32'(req.coef_value >>> (COEF_WIDTH - 32));
        end
        else
        begin : g_coef_narrow
            assign coef_n = 32'(req.coef_value) <<< (32 - COEF_WIDTH);
        end
        if (COORD_WIDTH > 32)
        begin : g_coord_wide
            assign x_n = 32'(req.coord_x >>> (COORD_WIDTH - 32));
            assign y_n = 32'(req.coord_y >>> (COORD_WIDTH - 32));
            assign z_n = 32'(req.coord_z >>> (COORD_WIDTH - 32));
        end
        else
        begin : g_coord_narrow
            assign x_n = 32'(req.coord_x) <<< (32 - COORD_WIDTH);
            assign y_n = 32'(req.coord_y) <<< (32 - COORD_WIDTH);
            assign z_n = 32'(req.coord_z) <<< (32 - COORD_WIDTH);
        end
    endgenerate

    always_comb
    begin
        entry.idx  = req.coef_index;
        entry.coef = coef_n;
        entry.x    = x_n;
        entry.y    = y_n;
        entry.z    = z_n;
        entry.kind = ENT_EVAL;
        keep       = 1'b0;
        case (req.action)
            ACT_LOAD_NUM:
            begin
                entry.kind = ENT_LOAD_NUM;
                keep       = (req.coef_index < IDX_WIDTH'(NUM_TERMS));
            end
            ACT_LOAD_DEN:
            begin
                entry.kind = ENT_LOAD_DEN;
                keep       = (req.coef_index < IDX_WIDTH'(NUM_TERMS));
            end
            ACT_EVAL:
            begin
                keep = 1'b1;
            end
            default:
            begin
                keep = 1'b0;   // drop undefined action
            end
        endcase
    end
endmodule
`default_nettype wire

// ----- hdl/rcube_back.sv -----
// Back end: coefficient tables, monomial and dot-product pipeline, divider.
// Depends on rcube_pkg.
`default_nettype none
module rcube_back
    import rcube_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire entry_t entry,
    input  wire logic   entry_empty,
    output logic        entry_pop,
    output logic        res_push,
    output result_t     res,
    input  wire logic   res_full,
    output logic        tbl_we,
    output logic        front_busy
);
    localparam int NDIV = 48;
    localparam int NST  = 11 + NDIV;   // valid stages in the pipe

    typedef struct packed {
        logic [64:0] rem;
        logic [63:0] den;
        logic [47:0] quo;
        logic [23:0] nlo;
        logic        neg;
        logic        dz;
        logic        ov;
    } div_stage_t;

    logic                   adv, pop_eval;
    logic [NST-1:0]         vld_reg;
    logic signed [31:0]     tnum_reg [NUM_TERMS];
    logic signed [31:0]     tden_reg [NUM_TERMS];

    logic signed [31:0]     x1_reg, y1_reg, z1_reg;
    logic signed [31:0]     x2_reg, y2_reg, z2_reg;
    logic signed [33:0]     xx2_reg, yy2_reg, zz2_reg, xy2_reg, xz2_reg, yz2_reg;
    logic signed [29:0]     mon_reg  [NUM_TERMS];
    logic signed [61:0]     prod_reg [2][NUM_TERMS];
    logic signed [63:0]     l1_reg [2][10];
    logic signed [63:0]     l2_reg [2][5];
    logic signed [63:0]     l3_reg [2][3];
    logic signed [63:0]     l4_reg [2][2];
    logic signed [63:0]     sum_reg [2];
    logic [63:0]            num_reg, den_reg;
    logic                   neg_reg, dz_reg;
    div_stage_t             div_reg [NDIV];
    result_t                res_reg;

    assign front_busy = vld_reg[0] || vld_reg[1] || vld_reg[2];
    assign adv        = !(vld_reg[NST-1] && res_full);
    assign pop_eval   = !entry_empty && (entry.kind == ENT_EVAL) && adv;
    assign tbl_we     = !entry_empty && (entry.kind != ENT_EVAL) && !front_busy;
    assign entry_pop  = pop_eval || tbl_we;
    assign res_push   = vld_reg[NST-1] && adv;
    assign res        = res_reg;

    function automatic logic signed [33:0] mul2(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return 34'(p >>> 30);
    endfunction

    // Degree-3 term straight to Q.24: floor by 30 then by 6
    function automatic logic signed [29:0] mul3(input logic signed [33:0] a,
                                                input logic signed [31:0] b);
        logic signed [65:0] p;
        p = a * b;
        return 30'(p >>> 36);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            for (int i = 0; i < NUM_TERMS; i++)
            begin
                tnum_reg[i] <= '0;
                tden_reg[i] <= '0;
            end
        end
        else
        begin
            if (adv)
            begin
                vld_reg <= {vld_reg[NST-2:0], pop_eval};
            end
            if (tbl_we)
            begin
                if (entry.kind == ENT_LOAD_NUM)
                begin
                    tnum_reg[entry.idx] <= entry.coef;
                end
                else
                begin
                    tden_reg[entry.idx] <= entry.coef;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_reg <= entry.x;
            y1_reg <= entry.y;
            z1_reg <= entry.z;

            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            z2_reg  <= z1_reg;
            xx2_reg <= mul2(x1_reg, x1_reg);
            yy2_reg <= mul2(y1_reg, y1_reg);
            zz2_reg <= mul2(z1_reg, z1_reg);
            xy2_reg <= mul2(x1_reg, y1_reg);
            xz2_reg <= mul2(x1_reg, z1_reg);
            yz2_reg <= mul2(y1_reg, z1_reg);

            mon_reg[0]  <= 30'sd1 <<< 24;
            mon_reg[1]  <= 30'(x2_reg >>> 6);
            mon_reg[2]  <= 30'(y2_reg >>> 6);
            mon_reg[3]  <= 30'(z2_reg >>> 6);
            mon_reg[4]  <= 30'(xy2_reg >>> 6);
            mon_reg[5]  <= 30'(xz2_reg >>> 6);
            mon_reg[6]  <= 30'(yz2_reg >>> 6);
            mon_reg[7]  <= 30'(xx2_reg >>> 6);
            mon_reg[8]  <= 30'(yy2_reg >>> 6);
            mon_reg[9]  <= 30'(zz2_reg >>> 6);
            mon_reg[10] <= mul3(xy2_reg, z2_reg);
            mon_reg[11] <= mul3(xx2_reg, x2_reg);
            mon_reg[12] <= mul3(yy2_reg, x2_reg);
            mon_reg[13] <= mul3(zz2_reg, x2_reg);
            mon_reg[14] <= mul3(xx2_reg, y2_reg);
            mon_reg[15] <= mul3(yy2_reg, y2_reg);
            mon_reg[16] <= mul3(zz2_reg, y2_reg);
            mon_reg[17] <= mul3(xx2_reg, z2_reg);
            mon_reg[18] <= mul3(yy2_reg, z2_reg);
            mon_reg[19] <= mul3(zz2_reg, z2_reg);

            for (int i = 0; i < NUM_TERMS; i++)
            begin
                prod_reg[0][i] <= 62'(tnum_reg[i]) * 62'(mon_reg[i]);
                prod_reg[1][i] <= 62'(tden_reg[i]) * 62'(mon_reg[i]);
            end

            // Pairwise reduction tree, odd element passes through
            for (int s = 0; s < 2; s++)
            begin
                for (int i = 0; i < 10; i++)
                begin
                    l1_reg[s][i] <= 64'(prod_reg[s][2*i]) + 64'(prod_reg[s][2*i+1]);
                end
                for (int i = 0; i < 5; i++)
                begin
                    l2_reg[s][i] <= l1_reg[s][2*i] + l1_reg[s][2*i+1];
                end
                l3_reg[s][0] <= l2_reg[s][0] + l2_reg[s][1];
                l3_reg[s][1] <= l2_reg[s][2] + l2_reg[s][3];
                l3_reg[s][2] <= l2_reg[s][4];
                l4_reg[s][0] <= l3_reg[s][0] + l3_reg[s][1];
                l4_reg[s][1] <= l3_reg[s][2];
                sum_reg[s]   <= l4_reg[s][0] + l4_reg[s][1];
            end

            num_reg <= sum_reg[0][63] ? 64'(-sum_reg[0]) : 64'(sum_reg[0]);
            den_reg <= sum_reg[1][63] ? 64'(-sum_reg[1]) : 64'(sum_reg[1]);
            neg_reg <= sum_reg[0][63] ^ sum_reg[1][63];
            dz_reg  <= (sum_reg[1] == '0);

            // Restoring division, one quotient bit a stage
            for (int k = 0; k < NDIV; k++)
            begin
                logic [64:0] r2;
                logic [63:0] dv;
                logic [23:0] nl;
                logic [47:0] qo;
                if (k == 0)
                begin
                    r2 = {24'd0, num_reg[63:24], num_reg[23]};
                    dv = den_reg;
                    nl = num_reg[23:0];
                    qo = '0;
                    div_reg[k].neg <= neg_reg;
                    div_reg[k].dz  <= dz_reg;
                    div_reg[k].ov  <= ({24'd0, num_reg} >= {den_reg, 24'd0});
                end
                else
                begin
                    r2 = {div_reg[k-1].rem[63:0], div_reg[k-1].nlo[23]};
                    dv = div_reg[k-1].den;
                    nl = div_reg[k-1].nlo;
                    qo = div_reg[k-1].quo;
                    div_reg[k].neg <= div_reg[k-1].neg;
                    div_reg[k].dz  <= div_reg[k-1].dz;
                    div_reg[k].ov  <= div_reg[k-1].ov;
                end
                div_reg[k].den <= dv;
                div_reg[k].nlo <= {nl[22:0], 1'b0};
                if (r2 >= {1'b0, dv})
                begin
                    div_reg[k].rem <= r2 - {1'b0, dv};
                    div_reg[k].quo <= {qo[46:0], 1'b1};
                end
                else
                begin
                    div_reg[k].rem <= r2;
                    div_reg[k].quo <= {qo[46:0], 1'b0};
                end
            end

            res_reg.denominator_zero <= 1'b0;
            res_reg.saturated        <= 1'b0;
            if (div_reg[NDIV-1].dz)
            begin
                res_reg.ratio_value      <= '0;
                res_reg.denominator_zero <= 1'b1;
            end
            else if (!div_reg[NDIV-1].neg)
            begin
                if (div_reg[NDIV-1].ov || div_reg[NDIV-1].quo[47])
                begin
                    res_reg.ratio_value <= {1'b0, {(RATIO_WIDTH-1){1'b1}}};
                    res_reg.saturated   <= 1'b1;
                end
                else
                begin
                    res_reg.ratio_value <= div_reg[NDIV-1].quo;
                end
            end
            else
            begin
                if (div_reg[NDIV-1].ov ||
                    (div_reg[NDIV-1].quo[47] && (div_reg[NDIV-1].quo[46:0] != '0)))
                begin
                    res_reg.ratio_value <= {1'b1, {(RATIO_WIDTH-1){1'b0}}};
                    res_reg.saturated   <= 1'b1;
                end
                else
                begin
                    res_reg.ratio_value <= -div_reg[NDIV-1].quo;
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- hdl/rational_cubic_3d_evaluator.sv -----
// Top level of the rational cubic evaluator: front end, work queue, back end
// and result queue. Depends on rcube_pkg, rcube_front, rcube_fifo, rcube_back.
//
//  channel   direction  handshake            payload
//  request   in         push / full          request_t (action, index, value, x, y, z)
//  result    out        pop / empty          result_t  (ratio, zero flag, saturated)
//
// One request a cycle is taken while the work queue is not full. The back pipe
// is: one issue stage, two monomial multiplier stages, the coefficient
// multipliers, a five-level adder tree, a sign stage, 48 restoring-division
// stages and a clamp stage. A coefficient load waits in the work queue while
// an evaluation sits in the three stages before the coefficient multipliers.
// Reset clears both coefficient tables at once; there is no clearing pass.
// A full result queue holds the whole back pipe when a result waits in the
// clamp stage; the work queue keeps taking requests until it is full.
`default_nettype none
module rational_cubic_3d_evaluator
    import rcube_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire request_t request,
    output logic          full,
    input  wire logic     pop,
    output result_t       result,
    output logic          empty
);
    localparam int EW = $bits(entry_t);
    localparam int RW = $bits(result_t);

    entry_t     fe_entry, wq_entry;
    logic       fe_keep;
    logic [EW-1:0] wq_rdata;
    logic       wq_empty, wq_pop;
    logic       rq_push, rq_full;
    result_t    be_res;
    logic [RW-1:0] rq_rdata;
    logic       tbl_we, front_busy;

    // Classify and normalise; dropped requests are taken but never queued
    rcube_front u_front (
        .req   (request),
        .entry (fe_entry),
        .keep  (fe_keep)
    );

    rcube_fifo #(.WIDTH(EW), .DEPTH(4)) u_work_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && fe_keep),
        .wdata (fe_entry),
        .full  (full),
        .pop   (wq_pop),
        .rdata (wq_rdata),
        .empty (wq_empty)
    );

    assign wq_entry = entry_t'(wq_rdata);

    rcube_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry       (wq_entry),
        .entry_empty (wq_empty),
        .entry_pop   (wq_pop),
        .res_push    (rq_push),
        .res         (be_res),
        .res_full    (rq_full),
        .tbl_we      (tbl_we),
        .front_busy  (front_busy)
    );

    // Result queue decouples the pipe from the consumer
    rcube_fifo #(.WIDTH(RW), .DEPTH(2)) u_result_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (rq_push),
        .wdata (be_res),
        .full  (rq_full),
        .pop   (pop),
        .rdata (rq_rdata),
        .empty (empty)
    );

    assign result = result_t'(rq_rdata);

    // A coefficient write never lands under an evaluation that still has to read it
    a_load_order: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> !front_busy)
        else $error("coefficient write while evaluation pending");

    // The pipe never offers a result to a full result queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        rq_push |-> !rq_full)
        else $error("result pushed into full queue");

    // A zero denominator never reports saturation as well
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(result.denominator_zero && result.saturated))
        else $error("zero denominator and saturation both set");
endmodule
`default_nettype wire
